FILE: hw/rtl/rrd_pkg.sv
// Shared types and constants for the row record deserializer.
// Used by rrd_parser, rrd_out_stage and row_record_deserializer_unit.
`default_nettype none

package rrd_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int COL_W       = 5;
    localparam int COUNT_W     = 6;
    localparam int TYPES_W     = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TYPES = 2'd1;

    localparam logic [2:0] KIND_NULL  = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_BOOL  = 3'd2;
    localparam logic [2:0] KIND_TLEN  = 3'd3;
    localparam logic [2:0] KIND_TBYTE = 3'd4;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_NULL   = 3'd1,
        PH_INT    = 3'd2,
        PH_BOOL   = 3'd3,
        PH_TLEN   = 3'd4,
        PH_TEXT   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [COL_W-1:0]   column_index;
        logic [2:0]         item_kind;
        logic signed [63:0] field_value;
        logic               row_end;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/row_record_deserializer_unit.sv
// Row record deserializer: the parser plus its result register.
// Depends on rrd_pkg, rrd_parser and rrd_out_stage.
`default_nettype none

// Takes one byte word of a stored row stream per cycle while the output stage
// can load, and returns one result word for each null, finished integer or
// boolean, text length and text byte; the last result of a row has row_end
// set. The parse state updates on the accepting edge and the result lands in
// the output register on that same edge, so results appear in the cycle after
// their byte. Input is accepted whenever the output register is empty or is
// being drained, which sustains one word per cycle. Configuration writes take
// effect at the next edge and should be issued only while the block is idle.
module row_record_deserializer_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [7:0]                     i_data_byte,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [rrd_pkg::COL_W-1:0]      o_column_index,
    output      logic [2:0]                     o_item_kind,
    output      logic signed [63:0]             o_field_value,
    output      logic                           o_row_end
);
    import rrd_pkg::*;

    logic    step;
    logic    res_valid;
    logic    can_load;
    t_result res;
    t_result out_res;

    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    rrd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rrd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_column_index = out_res.column_index;
    assign o_item_kind    = out_res.item_kind;
    assign o_field_value  = out_res.field_value;
    assign o_row_end      = out_res.row_end;

endmodule

`default_nettype wire

FILE: hw/rtl/rrd_parser.sv
// Parse state machine and configuration registers of the row deserializer.
// Consumes one accepted word per cycle; depends on rrd_pkg.
`default_nettype none

module rrd_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_step,
    input  wire logic [7:0]                     i_data_byte,
    output      logic                           o_res_valid,
    output      rrd_pkg::t_result               o_res
);
    import rrd_pkg::*;

    logic [COUNT_W-1:0] r_col_count;
    logic [TYPES_W-1:0] r_col_types;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_bc, n_bc;
    logic [COL_W-1:0]   r_col, n_col;
    logic [63:0]        r_asm, n_asm;
    logic [31:0]        r_tbl, n_tbl;

    logic [COUNT_W-1:0] eff_count;
    logic               last_col;
    logic [1:0]         type_code;
    logic [63:0]        asm_lane;
    logic [31:0]        tbl_dec;
    logic               fin;
    logic [2:0]         res_kind;
    logic [63:0]        res_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= COUNT_W'(1);
            r_col_types <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_COLUMN_COUNT) begin
                r_col_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index == CFG_COLUMN_TYPES) begin
                r_col_types <= i_cfg_data[TYPES_W-1:0];
            end
        end
    end

    // A count of zero behaves as one column, anything too large as the maximum.
    always_comb begin
        if (r_col_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (r_col_count > COUNT_W'(MAX_COLUMNS)) begin
            eff_count = COUNT_W'(MAX_COLUMNS);
        end else begin
            eff_count = r_col_count;
        end
    end

    assign last_col  = ({1'b0, r_col} + COUNT_W'(1)) >= eff_count;
    assign type_code = r_col_types[{r_col, 1'b0} +: 2];
    assign tbl_dec   = r_tbl - 32'd1;

    always_comb begin
        asm_lane = r_asm;
        asm_lane[{r_bc, 3'b000} +: 8] = i_data_byte;
    end

    always_comb begin
        n_phase     = r_phase;
        n_bc        = r_bc;
        n_col       = r_col;
        n_asm       = r_asm;
        n_tbl       = r_tbl;
        o_res_valid = 1'b0;
        fin         = 1'b0;
        res_kind    = KIND_NULL;
        res_value   = '0;

        unique case (r_phase)
            PH_NULL: begin
                if (i_data_byte != 8'd0) begin
                    fin = 1'b1;
                end else begin
                    n_bc  = '0;
                    n_asm = '0;
                    if (type_code[1]) begin
                        n_phase = PH_TLEN;
                    end else if (type_code[0]) begin
                        n_phase = PH_BOOL;
                    end else begin
                        n_phase = PH_INT;
                    end
                end
            end
            PH_INT: begin
                n_asm = asm_lane;
                if (r_bc == 3'd7) begin
                    fin       = 1'b1;
                    res_kind  = KIND_INT;
                    res_value = asm_lane;
                end else begin
                    n_bc = r_bc + 3'd1;
                end
            end
            PH_BOOL: begin
                fin       = 1'b1;
                res_kind  = KIND_BOOL;
                res_value = {63'd0, (i_data_byte != 8'd0)};
            end
            PH_TLEN: begin
                n_asm = asm_lane;
                if (r_bc[1:0] != 2'd3) begin
                    n_bc = r_bc + 3'd1;
                end else begin
                    n_tbl    = asm_lane[31:0];
                    res_kind = KIND_TLEN;
                    if (asm_lane[31:0] == 32'd0) begin
                        fin = 1'b1;
                    end else begin
                        o_res_valid = 1'b1;
                        res_value   = {32'd0, asm_lane[31:0]};
                        n_phase     = PH_TEXT;
                        n_bc        = '0;
                        n_asm       = '0;
                    end
                end
            end
            PH_TEXT: begin
                n_tbl     = tbl_dec;
                res_kind  = KIND_TBYTE;
                res_value = {56'd0, i_data_byte};
                if (tbl_dec == 32'd0) begin
                    fin = 1'b1;
                end else begin
                    o_res_valid = 1'b1;
                end
            end
            default: begin
                // Row length prefix: skipped without any check.
                if (r_bc[1:0] == 2'd3) begin
                    n_phase = PH_NULL;
                    n_bc    = '0;
                    n_col   = '0;
                end else begin
                    n_phase = PH_PREFIX;
                    n_bc    = {1'b0, r_bc[1:0] + 2'd1};
                end
            end
        endcase

        // Completing a column moves to the next one or closes the row.
        if (fin) begin
            o_res_valid = 1'b1;
            n_bc        = '0;
            n_asm       = '0;
            if (last_col) begin
                n_phase = PH_PREFIX;
                n_col   = '0;
            end else begin
                n_phase = PH_NULL;
                n_col   = r_col + COL_W'(1);
            end
        end
    end

    assign o_res.column_index = r_col;
    assign o_res.item_kind    = res_kind;
    assign o_res.field_value  = res_value;
    assign o_res.row_end      = fin && last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_bc    <= '0;
            r_col   <= '0;
            r_asm   <= '0;
            r_tbl   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_col   <= n_col;
            r_asm   <= n_asm;
            r_tbl   <= n_tbl;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rrd_out_stage.sv
// Result register of the row deserializer with its valid/ready handshake.
// Depends on rrd_pkg for the result struct.
`default_nettype none

module rrd_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire rrd_pkg::t_result   i_res,
    output      logic               o_can_load,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      rrd_pkg::t_result   o_res
);
    import rrd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register may be refilled in the same cycle its word is taken.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: bench/row_record_deserializer_unit_test.sv
// Self-checking bench for row_record_deserializer_unit: directed rows, then random rows per schema.
// Depends on rrd_pkg and the RTL of the unit; the scoreboard class tracks the parse state itself.
`timescale 1ns / 100ps

module row_record_deserializer_unit_test;

    import rrd_pkg::*;

    class row_result_scoreboard;
        logic [COUNT_W-1:0] count_reg;
        logic [TYPES_W-1:0] types_reg;
        t_phase             phase;
        logic [2:0]         nbytes;
        logic [COL_W-1:0]   col;
        logic [63:0]        acc;
        logic [31:0]        text_left;
        t_result            pending_results[$];
        int                 errors;
        int                 results_seen;
        int                 rows_ended;
        int                 kind_seen[5];

        function new();
            count_reg = 1;
            types_reg = '0;
            phase     = PH_PREFIX;
            nbytes    = 0;
            col       = 0;
            acc       = '0;
            text_left = '0;
            errors    = 0;
            results_seen = 0;
            rows_ended = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_COLUMN_COUNT) count_reg = data[COUNT_W-1:0];
            else if (idx == CFG_COLUMN_TYPES) types_reg = data;
        endfunction

        function int eff_columns();
            int c;
            c = count_reg;
            if (c == 0) c = 1;
            if (c > MAX_COLUMNS) c = MAX_COLUMNS;
            return c;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(logic [2:0] kind, logic [63:0] value, logic end_mark);
            t_result r;
            r.column_index = col;
            r.item_kind    = kind;
            r.field_value  = value;
            r.row_end      = end_mark;
            pending_results.push_back(r);
        endfunction

        // Emits the result that completes the current column and moves on.
        function void close_column(logic [2:0] kind, logic [63:0] value);
            bit last;
            last = (int'(col) + 1) >= eff_columns();
            push_result(kind, value, last);
            if (last) begin
                phase = PH_PREFIX;
                col   = 0;
            end else begin
                phase = PH_NULL;
                col   = col + 1'b1;
            end
            nbytes = 0;
            acc    = '0;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [1:0] type_code;
            case (phase)
                PH_NULL: begin
                    if (b != 0) begin
                        close_column(KIND_NULL, 64'd0);
                    end else begin
                        type_code = types_reg[2*col +: 2];
                        nbytes = 0;
                        acc    = '0;
                        if (type_code[1]) phase = PH_TLEN;
                        else if (type_code[0]) phase = PH_BOOL;
                        else phase = PH_INT;
                    end
                end
                PH_INT: begin
                    acc = acc | (64'(b) << (8 * nbytes));
                    if (nbytes == 3'd7) close_column(KIND_INT, acc);
                    else nbytes = nbytes + 1'b1;
                end
                PH_BOOL: close_column(KIND_BOOL, 64'(b != 0));
                PH_TLEN: begin
                    acc = acc | (64'(b) << (8 * nbytes[1:0]));
                    if (nbytes[1:0] != 2'd3) begin
                        nbytes = nbytes + 1'b1;
                    end else begin
                        text_left = acc[31:0];
                        if (text_left == 0) begin
                            close_column(KIND_TLEN, 64'd0);
                        end else begin
                            push_result(KIND_TLEN, 64'(text_left), 1'b0);
                            phase  = PH_TEXT;
                            nbytes = 0;
                            acc    = '0;
                        end
                    end
                end
                PH_TEXT: begin
                    text_left = text_left - 1;
                    if (text_left == 0) close_column(KIND_TBYTE, 64'(b));
                    else push_result(KIND_TBYTE, 64'(b), 1'b0);
                end
                default: begin
                    if (nbytes[1:0] == 2'd3) begin
                        phase  = PH_NULL;
                        nbytes = 0;
                        col    = 0;
                    end else begin
                        nbytes = nbytes + 1'b1;
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < 40) $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [COL_W-1:0] got_col, logic [2:0] got_kind,
                          logic signed [63:0] got_value, logic got_end);
            t_result want;
            results_seen++;
            if (got_kind < 5) kind_seen[got_kind]++;
            if (got_end === 1'b1) rows_ended++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
            end else begin
                want = pending_results.pop_front();
                if (got_col !== want.column_index)
                    report_mismatch($sformatf("word %0d column_index got %0d want %0d",
                                              results_seen, got_col, want.column_index));
                if (got_kind !== want.item_kind)
                    report_mismatch($sformatf("word %0d item_kind got %0d want %0d",
                                              results_seen, got_kind, want.item_kind));
                if (got_value !== want.field_value)
                    report_mismatch($sformatf("word %0d field_value got %h want %h",
                                              results_seen, got_value, want.field_value));
                if (got_end !== want.row_end)
                    report_mismatch($sformatf("word %0d row_end got %b want %b",
                                              results_seen, got_end, want.row_end));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COL_W-1:0]      o_column_index;
    logic [2:0]            o_item_kind;
    logic signed [63:0]    o_field_value;
    logic                  o_row_end;

    row_record_deserializer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_column_index (o_column_index),
        .o_item_kind    (o_item_kind),
        .o_field_value  (o_field_value),
        .o_row_end      (o_row_end)
    );

    row_result_scoreboard sb;

    logic [COUNT_W-1:0] stim_count;
    logic [TYPES_W-1:0] stim_types;
    logic [7:0]         row_buf[$];
    int                 words_sent;
    int                 phases_run;
    bit                 tx_free;
    bit                 rx_free;
    int                 rx_stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Output side: random back-pressure, mostly short stalls with a few long ones.
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            i_out_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_free || $urandom_range(99) < 70) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            rx_stall_left <= ($urandom_range(99) < 93) ? $urandom_range(3) : $urandom_range(10, 60);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_column_index, o_item_kind, o_field_value, o_row_end);
    end

    function int stim_columns();
        int c;
        c = stim_count;
        if (c == 0) c = 1;
        if (c > MAX_COLUMNS) c = MAX_COLUMNS;
        return c;
    endfunction

    function int pick_gap();
        int r;
        if (tx_free) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task send_word(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
        words_sent++;
    endtask

    task stop_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        if (idx == CFG_COLUMN_COUNT) stim_count = data[COUNT_W-1:0];
        else stim_types = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_word(bytes[i]);
    endtask

    function logic [63:0] pick_integer();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function int pick_text_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 96) return $urandom_range(1, 6);
        return $urandom_range(100, 300);
    endfunction

    // Builds one well-formed row for the current schema into row_buf.
    function void build_row();
        logic [1:0]  type_code;
        logic [63:0] v;
        int          len;
        row_buf.delete();
        repeat (4) row_buf.push_back(8'($urandom_range(255)));
        for (int c = 0; c < stim_columns(); c++) begin
            if ($urandom_range(99) < 12) begin
                row_buf.push_back(8'($urandom_range(1, 255)));
            end else begin
                row_buf.push_back(8'h00);
                type_code = stim_types[2*c +: 2];
                if (type_code[1]) begin
                    len = pick_text_len();
                    for (int k = 0; k < 4; k++) row_buf.push_back(len[8*k +: 8]);
                    repeat (len) row_buf.push_back(8'($urandom_range(255)));
                end else if (type_code[0]) begin
                    row_buf.push_back($urandom_range(1) ? 8'($urandom_range(255)) : 8'h00);
                end else begin
                    v = pick_integer();
                    for (int k = 0; k < 8; k++) row_buf.push_back(v[8*k +: 8]);
                end
            end
        end
    endfunction

    // Feeds filler until the parser stands at a row boundary again. Length bytes
    // are kept at zero so a stray text column stays short.
    task resync();
        logic [7:0] b;
        while (!(sb.phase == PH_PREFIX && sb.nbytes == 0)) begin
            case (sb.phase)
                PH_NULL: b = 8'($urandom_range(1, 255));
                PH_TLEN: b = 8'h00;
                default: b = 8'($urandom_range(255));
            endcase
            send_word(b);
        end
    endtask

    task send_random_phase(input int budget);
        int         start;
        int         r;
        int         cut;
        logic [7:0] b;
        start = words_sent;
        while (words_sent - start < budget) begin
            r = $urandom_range(99);
            build_row();
            if (r < 88) begin
                send_bytes(row_buf);
            end else if (r < 95) begin
                cut = $urandom_range(1, row_buf.size() - 1);
                for (int i = 0; i < cut; i++) send_word(row_buf[i]);
                resync();
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    b = 8'($urandom_range(255));
                    if (sb.phase == PH_TLEN && sb.nbytes != 0) b = 8'h00;
                    send_word(b);
                end
                resync();
            end
        end
        stop_input();
    endtask

    initial begin
        logic [63:0] data;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_out_ready   = 1'b0;
        rx_stall_left = 0;
        stim_count    = 1;
        stim_types    = '0;
        words_sent    = 0;
        phases_run    = 0;
        tx_free       = 1'b0;
        rx_free       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: boolean, empty text with type code 3, most negative integer,
        // then a null, a one-byte text and a null that ends the row.
        write_register(CFG_COLUMN_COUNT, 64'd3);
        write_register(CFG_COLUMN_TYPES, 64'b00_11_01);
        send_bytes('{8'h11, 8'h22, 8'h33, 8'h44, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h80});
        send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00,
                     8'h00, 8'hFF, 8'h01});
        // Shrink the row while column 1 is next; that column must close the row.
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        stop_input();
        settle();
        write_register(CFG_COLUMN_COUNT, 64'd1);
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        stop_input();
        settle();

        for (int p = 0; p < 8; p++) begin
            tx_free = (p == 2 || p == 5);
            rx_free = (p == 2 || p == 5 || p == 6);
            data = {$urandom, $urandom};
            case (p)
                0: begin
                    write_register(CFG_COLUMN_COUNT, 64'd1);
                    write_register(CFG_COLUMN_TYPES, 64'd0);
                end
                1: begin
                    write_register(CFG_COLUMN_COUNT, 64'd0);
                    write_register(CFG_COLUMN_TYPES, data);
                end
                2: begin
                    write_register(CFG_COLUMN_COUNT, 64'd32);
                    write_register(CFG_COLUMN_TYPES, data);
                end
                3: begin
                    write_register(CFG_COLUMN_COUNT, 64'd63);
                    write_register(CFG_COLUMN_TYPES, '1);
                end
                4: begin
                    write_register(CFG_COLUMN_COUNT, 64'd40);
                    write_register(CFG_COLUMN_TYPES, 64'h5555_5555_5555_5555);
                end
                5: begin
                    write_register(CFG_COLUMN_COUNT, 64'd2);
                    write_register(CFG_COLUMN_TYPES, data);
                end
                6: begin
                    // Upper data bits are junk; only the low six count.
                    write_register(CFG_COLUMN_COUNT,
                                   {data[63:6], 6'($urandom_range(1, MAX_COLUMNS))});
                    write_register(CFG_COLUMN_TYPES, {$urandom, $urandom});
                end
                default: begin
                    write_register(CFG_COLUMN_COUNT, 64'd7);
                    write_register(CFG_COLUMN_TYPES, data);
                end
            endcase
            send_random_phase(60);
            settle();
            phases_run++;
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
        $display("Sent %0d byte words over %0d schema settings plus directed rows; %0d rows closed.",
                 words_sent, phases_run, sb.rows_ended);
        $display("Results: %0d null, %0d integer, %0d boolean, %0d text length, %0d text byte.",
                 sb.kind_seen[KIND_NULL], sb.kind_seen[KIND_INT], sb.kind_seen[KIND_BOOL],
                 sb.kind_seen[KIND_TLEN], sb.kind_seen[KIND_TBYTE]);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
